// File: rtl/rre_pkg.sv
// ----------------------------------------------------------------------------
// rre_pkg
// Shared types and constants for the rectangle rotation engine.
// ----------------------------------------------------------------------------
package rre_pkg;

  localparam int PIX_W   = 16;
  localparam int POS_W   = 8;
  localparam int LEN_W   = 9;
  localparam int COORD_W = 9;
  localparam int ROT_W   = 2;
  localparam int IDX_W   = 2 * LEN_W;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef enum logic [ROT_W-1:0] {
    ROT_NONE = 2'd0,
    ROT_90   = 2'd1,
    ROT_180  = 2'd2,
    ROT_270  = 2'd3
  } rot_t;

  typedef enum logic [2:0] {
    REG_SRC_X       = 3'd0,
    REG_SRC_Y       = 3'd1,
    REG_RECT_WIDTH  = 3'd2,
    REG_RECT_HEIGHT = 3'd3,
    REG_ROTATION    = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_PASS  = 2'd2
  } op_t;

  typedef struct packed {
    rot_t             rot;
    logic [LEN_W-1:0] w;
    logic [LEN_W-1:0] h;
    logic [IDX_W-1:0] total;
    logic             app;
  } geom_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] addr;
    logic [PIX_W-1:0] pixel;
    logic             last;
  } qent_t;

endpackage

// File: rtl/rre_front.sv
// ----------------------------------------------------------------------------
// rre_front
// Takes requests, tracks load/read position and forms store operations.
// ----------------------------------------------------------------------------
module rre_front import rre_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  logic             mode,
  input  logic [PIX_W-1:0] pixel_in,
  input  geom_t            geom,
  input  logic             cfg_clear,
  output logic             push_valid,
  input  logic             push_ready,
  output qent_t            push_data
);

  logic             s0_valid;
  logic             s0_mode;
  logic [PIX_W-1:0] s0_pixel;
  logic             s0_done;

  logic [LEN_W-1:0] col;
  logic [LEN_W-1:0] row;
  logic [IDX_W-1:0] idx;

  logic [LEN_W-1:0] col_n, row_n, col_inc, row_inc;
  logic [LEN_W-1:0] col_next, row_next;
  logic [LEN_W-1:0] hm1y, wm1x;
  logic [LEN_W-1:0] mul_a, mul_b, mul_c;
  logic [IDX_W-1:0] waddr;
  logic [IDX_W-1:0] idx_n, idx_next;
  logic             last;

  always_comb begin
    if (col >= geom.w || row >= geom.h) begin
      col_n = '0;
      row_n = '0;
    end else begin
      col_n = col;
      row_n = row;
    end
    hm1y = geom.h - LEN_W'(1) - row_n;
    wm1x = geom.w - LEN_W'(1) - col_n;
    case (geom.rot)
      ROT_90: begin
        mul_a = col_n;
        mul_b = geom.h;
        mul_c = hm1y;
      end
      ROT_180: begin
        mul_a = hm1y;
        mul_b = geom.w;
        mul_c = wm1x;
      end
      default: begin
        mul_a = wm1x;
        mul_b = geom.h;
        mul_c = row_n;
      end
    endcase
    waddr = IDX_W'({{LEN_W{1'b0}}, mul_a} * {{LEN_W{1'b0}}, mul_b})
          + IDX_W'(mul_c);

    col_inc  = col_n + LEN_W'(1);
    row_inc  = row_n + LEN_W'(1);
    col_next = col_inc;
    row_next = row_n;
    if (col_inc >= geom.w) begin
      col_next = '0;
      row_next = (row_inc >= geom.h) ? '0 : row_inc;
    end

    idx_n    = (idx >= geom.total) ? '0 : idx;
    last     = (idx_n == geom.total - IDX_W'(1));
    idx_next = last ? '0 : idx_n + IDX_W'(1);
  end

  always_comb begin
    push_valid      = s0_valid && (s0_mode || geom.app);
    s0_done         = s0_valid && (!push_valid || push_ready);
    item_ready      = !s0_valid || s0_done;
    push_data.op    = !s0_mode ? OP_WRITE : (geom.app ? OP_READ : OP_PASS);
    push_data.addr  = s0_mode ? idx_n : waddr;
    push_data.pixel = s0_pixel;
    push_data.last  = s0_mode && geom.app && last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (item_ready) begin
      s0_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      s0_mode  <= mode;
      s0_pixel <= pixel_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_clear) begin
      col <= '0;
      row <= '0;
      idx <= '0;
    end else if (s0_done && geom.app) begin
      if (s0_mode) begin
        idx <= idx_next;
      end else begin
        col <= col_next;
        row <= row_next;
      end
    end
  end

endmodule

// File: rtl/rre_queue.sv
// ----------------------------------------------------------------------------
// rre_queue
// Short FIFO of store operations between front and back.
// ----------------------------------------------------------------------------
module rre_queue import rre_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  qent_t push_data,
  output logic  pop_valid,
  input  logic  pop,
  output qent_t pop_data
);

  qent_t           entries [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count != (Q_AW+1)'(Q_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + Q_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + Q_AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + (Q_AW+1)'(1);
        2'b01:   count <= count - (Q_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// File: rtl/rre_back.sv
// ----------------------------------------------------------------------------
// rre_back
// Pixel store, store access stage and result register.
// ----------------------------------------------------------------------------
module rre_back import rre_pkg::*; #(
  parameter int SCREEN_SIDE = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  qent_t            q_data,
  output logic             q_pop,
  output logic             result_valid,
  input  logic             result_ready,
  output logic [PIX_W-1:0] pixel_out,
  output logic             last_pixel,
  output logic             applied
);

  localparam int STORE_DEPTH = SCREEN_SIDE * SCREEN_SIDE;
  localparam int AW          = $clog2(STORE_DEPTH);

  logic [PIX_W-1:0] store [STORE_DEPTH];
  logic [PIX_W-1:0] rdata;
  logic [AW-1:0]    addr;

  logic b1_valid;
  logic b1_last;
  logic b1_app;
  logic b1_move;
  logic b1_load;

  assign addr    = AW'(q_data.addr);
  assign b1_move = b1_valid && (!result_valid || result_ready);
  assign q_pop   = q_valid && (q_data.op == OP_WRITE || !b1_valid || b1_move);
  assign b1_load = q_pop && (q_data.op != OP_WRITE);

  always_ff @(posedge clk) begin
    if (q_pop && q_data.op == OP_WRITE) begin
      store[addr] <= q_data.pixel;
    end
    if (q_pop && q_data.op == OP_READ) begin
      rdata <= store[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
    end else if (b1_load) begin
      b1_valid <= 1'b1;
    end else if (b1_move) begin
      b1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b1_load) begin
      b1_last <= q_data.last;
      b1_app  <= (q_data.op == OP_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (b1_move) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b1_move) begin
      pixel_out  <= b1_app ? rdata : '0;
      last_pixel <= b1_last;
      applied    <= b1_app;
    end
  end

endmodule

// File: rtl/rect_rotation_engine_unit.sv
// A read passes the front stage, store queue, store access stage and result
// register. Throughput: one request per cycle while the queue has room; the
// single-port pixel store takes one access per cycle. Loads give no result.
// Reset clears configuration to its defaults and all counters and valids;
// the pixel store is not cleared and reads back only what was loaded.
// ----------------------------------------------------------------------------
// rect_rotation_engine_unit
// Rotates a pixel rectangle by quarter turns through a pixel store.
// ----------------------------------------------------------------------------
module rect_rotation_engine_unit import rre_pkg::*; #(
  parameter int SCREEN_SIDE = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [4:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      item_valid,
  output logic                      item_ready,
  input  logic                      mode,
  input  logic [PIX_W-1:0]          pixel_in,
  output logic                      result_valid,
  input  logic                      result_ready,
  output logic [PIX_W-1:0]          pixel_out,
  output logic                      last_pixel,
  output logic                      applied,
  output logic signed [COORD_W-1:0] dest_x,
  output logic signed [COORD_W-1:0] dest_y,
  output logic [LEN_W-1:0]          dest_width,
  output logic [LEN_W-1:0]          dest_height
);

  localparam int STORE_DEPTH = SCREEN_SIDE * SCREEN_SIDE;
  localparam logic [COORD_W-1:0] SIDE_LO = COORD_W'(SCREEN_SIDE);
  localparam logic [LEN_W-1:0]   LEN_RST = LEN_W'(256);

  logic [POS_W-1:0] src_x;
  logic [POS_W-1:0] src_y;
  logic [LEN_W-1:0] rect_width;
  logic [LEN_W-1:0] rect_height;
  rot_t             rotation;

  reg_idx_t reg_idx;
  logic     wr_en;
  logic     cfg_clear;

  geom_t            geom;
  logic [IDX_W-1:0] area;
  logic             app_next;
  logic [COORD_W-1:0] dx_next, dy_next;
  logic [LEN_W-1:0]   dw_next, dh_next;

  logic  push_valid, push_ready;
  qent_t push_data;
  logic  q_valid, q_pop;
  qent_t q_data;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    cfg_clear = 1'b0;
    if (wr_en) begin
      case (reg_idx)
        REG_SRC_X, REG_SRC_Y, REG_RECT_WIDTH, REG_RECT_HEIGHT, REG_ROTATION:
          cfg_clear = 1'b1;
        default: cfg_clear = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_x       <= '0;
      src_y       <= '0;
      rect_width  <= LEN_RST;
      rect_height <= LEN_RST;
      rotation    <= ROT_NONE;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SRC_X:       src_x       <= pwdata[POS_W-1:0];
        REG_SRC_Y:       src_y       <= pwdata[POS_W-1:0];
        REG_RECT_WIDTH:  rect_width  <= pwdata[LEN_W-1:0];
        REG_RECT_HEIGHT: rect_height <= pwdata[LEN_W-1:0];
        REG_ROTATION:    rotation    <= rot_t'(pwdata[ROT_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SRC_X:       prdata = 32'(src_x);
      REG_SRC_Y:       prdata = 32'(src_y);
      REG_RECT_WIDTH:  prdata = 32'(rect_width);
      REG_RECT_HEIGHT: prdata = 32'(rect_height);
      REG_ROTATION:    prdata = 32'(rotation);
      default:         prdata = '0;
    endcase
  end

  // rectangle geometry, derived from the configuration and registered
  always_comb begin
    area = IDX_W'({{LEN_W{1'b0}}, rect_width} * {{LEN_W{1'b0}}, rect_height});
    app_next = (rotation != ROT_NONE) && (rect_width != '0) && (rect_height != '0)
            && (32'(area) <= 32'(STORE_DEPTH));
    dx_next = COORD_W'(src_x);
    dy_next = COORD_W'(src_y);
    dw_next = rect_width;
    dh_next = rect_height;
    if (app_next) begin
      case (rotation)
        ROT_90: begin
          dw_next = rect_height;
          dh_next = rect_width;
          dx_next = SIDE_LO - COORD_W'(src_y) - rect_height;
          dy_next = COORD_W'(src_x);
        end
        ROT_180: begin
          dx_next = SIDE_LO - COORD_W'(src_x) - rect_width;
          dy_next = SIDE_LO - COORD_W'(src_y) - rect_height;
        end
        default: begin
          dw_next = rect_height;
          dh_next = rect_width;
          dx_next = COORD_W'(src_y);
          dy_next = SIDE_LO - COORD_W'(src_x) - rect_width;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      geom.rot    <= ROT_NONE;
      geom.w      <= LEN_RST;
      geom.h      <= LEN_RST;
      geom.total  <= IDX_W'(65536);
      geom.app    <= 1'b0;
      dest_x      <= '0;
      dest_y      <= '0;
      dest_width  <= LEN_RST;
      dest_height <= LEN_RST;
    end else begin
      geom.rot    <= rotation;
      geom.w      <= rect_width;
      geom.h      <= rect_height;
      geom.total  <= area;
      geom.app    <= app_next;
      dest_x      <= dx_next;
      dest_y      <= dy_next;
      dest_width  <= dw_next;
      dest_height <= dh_next;
    end
  end

  rre_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .mode       (mode),
    .pixel_in   (pixel_in),
    .geom       (geom),
    .cfg_clear  (cfg_clear),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  rre_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  rre_back #(
    .SCREEN_SIDE (SCREEN_SIDE)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .pixel_out    (pixel_out),
    .last_pixel   (last_pixel),
    .applied      (applied)
  );

endmodule

// File: rtl/rre_checker.sv
// ----------------------------------------------------------------------------
// rre_checker
// Port-level checks for the rectangle rotation engine.
// ----------------------------------------------------------------------------
module rre_checker import rre_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             pready,
  input logic             result_valid,
  input logic             result_ready,
  input logic [PIX_W-1:0] pixel_out,
  input logic             last_pixel,
  input logic             applied,
  input logic [LEN_W-1:0] dest_width,
  input logic [LEN_W-1:0] dest_height
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(pixel_out)
      && $stable(last_pixel) && $stable(applied))
    else $error("stalled result changed");

  a_pass: assert property (@(posedge clk) disable iff (rst)
    result_valid && !applied |-> pixel_out == '0 && !last_pixel)
    else $error("pass-through result carries pixel data");

  a_dims: assert property (@(posedge clk) disable iff (rst)
    result_valid && applied |-> dest_width != '0 && dest_height != '0)
    else $error("rotated result with empty destination");

  a_rst: assert property (@(posedge clk)
    rst |=> !result_valid && pready)
    else $error("result valid straight after reset");

endmodule

bind rect_rotation_engine_unit rre_checker u_rre_checker (
  .clk          (clk),
  .rst          (rst),
  .pready       (pready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .pixel_out    (pixel_out),
  .last_pixel   (last_pixel),
  .applied      (applied),
  .dest_width   (dest_width),
  .dest_height  (dest_height)
);

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the rectangle rotation engine.
// Load and read requests go in bursts with random gaps while the result side
// stalls on its own pattern. Register settings change over APB between
// phases and are read back. An in-bench model of the pixel store and its
// counters predicts every result, which is checked field by field.
// ----------------------------------------------------------------------------
module tb;
  import rre_pkg::*;

  localparam int SIDE        = 256;
  localparam int STORE_DEPTH = SIDE * SIDE;
  localparam int NUM_REGS    = 5;
  localparam int WANT_REQS   = 1250;
  localparam int IDLE_LIMIT  = 2000;
  localparam int DRAIN_WAIT  = 8;
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel;
    logic               last;
    logic               applied;
    logic [COORD_W-1:0] dest_x;
    logic [COORD_W-1:0] dest_y;
    logic [LEN_W-1:0]   dest_w;
    logic [LEN_W-1:0]   dest_h;
  } rot_result_t;

  class rotation_scoreboard;
    logic [POS_W-1:0] src_x, src_y;
    logic [LEN_W-1:0] width, height;
    rot_t             rot;
    int unsigned      load_col, load_row, read_idx;
    bit [PIX_W-1:0]   pixel_mem [STORE_DEPTH];
    bit               written [STORE_DEPTH];
    rot_result_t      pending_pixels [$];
    int               errors, loads, ignored, reads, checked, settings;

    function new();
      src_x  = '0;
      src_y  = '0;
      width  = LEN_W'(SIDE);
      height = LEN_W'(SIDE);
      rot    = ROT_NONE;
      load_col = 0;
      load_row = 0;
      read_idx = 0;
    endfunction

    function void flag(string what, int unsigned exp_v, int unsigned act_v);
      errors++;
      if (errors <= 10)
        $display("MISMATCH %s: expected 0x%0h, got 0x%0h", what, exp_v, act_v);
    endfunction

    function int unsigned area();
      return int'(width) * int'(height);
    endfunction

    function bit active();
      return rot != ROT_NONE && width != 0 && height != 0 && area() <= STORE_DEPTH;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        REG_SRC_X:       src_x  = data[POS_W-1:0];
        REG_SRC_Y:       src_y  = data[POS_W-1:0];
        REG_RECT_WIDTH:  width  = data[LEN_W-1:0];
        REG_RECT_HEIGHT: height = data[LEN_W-1:0];
        REG_ROTATION:    rot    = rot_t'(data[ROT_W-1:0]);
        default:         return;
      endcase
      load_col = 0;
      load_row = 0;
      read_idx = 0;
      settings++;
    endfunction

    function logic [31:0] reg_value(logic [2:0] idx);
      case (idx)
        REG_SRC_X:       return 32'(src_x);
        REG_SRC_Y:       return 32'(src_y);
        REG_RECT_WIDTH:  return 32'(width);
        REG_RECT_HEIGHT: return 32'(height);
        REG_ROTATION:    return 32'(rot);
        default:         return '0;
      endcase
    endfunction

    // a read must only land on a store entry loaded since reset
    function bit read_allowed();
      int unsigned idx;
      if (!active())
        return 1'b1;
      idx = (read_idx >= area()) ? 0 : read_idx;
      return written[idx];
    endfunction

    function int pending();
      return pending_pixels.size();
    endfunction

    function void note_request(logic m, logic [PIX_W-1:0] pix);
      int          w, h, x, y, dx, dy, dw, dh;
      int unsigned addr, total;
      rot_result_t exp_r;
      w = int'(width);
      h = int'(height);
      if (m == MODE_LOAD) begin
        if (!active()) begin
          ignored++;
          return;
        end
        loads++;
        if (load_col >= w || load_row >= h) begin
          load_col = 0;
          load_row = 0;
        end
        x = load_col;
        y = load_row;
        case (rot)
          ROT_90:  addr = x * h + (h - 1 - y);
          ROT_180: addr = (h - 1 - y) * w + (w - 1 - x);
          default: addr = (w - 1 - x) * h + y;
        endcase
        if (addr < STORE_DEPTH) begin
          pixel_mem[addr] = pix;
          written[addr]   = 1'b1;
        end
        load_col++;
        if (load_col >= w) begin
          load_col = 0;
          load_row++;
          if (load_row >= h)
            load_row = 0;
        end
        return;
      end
      reads++;
      dx = int'(src_x);
      dy = int'(src_y);
      dw = w;
      dh = h;
      exp_r = '0;
      if (active()) begin
        case (rot)
          ROT_90: begin
            dw = h; dh = w;
            dx = SIDE - int'(src_y) - h;
            dy = int'(src_x);
          end
          ROT_180: begin
            dx = SIDE - int'(src_x) - w;
            dy = SIDE - int'(src_y) - h;
          end
          default: begin
            dw = h; dh = w;
            dx = int'(src_y);
            dy = SIDE - int'(src_x) - w;
          end
        endcase
        total = area();
        if (read_idx >= total)
          read_idx = 0;
        exp_r.pixel   = pixel_mem[read_idx];
        exp_r.last    = (read_idx == total - 1);
        exp_r.applied = 1'b1;
        read_idx = exp_r.last ? 0 : read_idx + 1;
      end
      exp_r.dest_x = dx[COORD_W-1:0];
      exp_r.dest_y = dy[COORD_W-1:0];
      exp_r.dest_w = dw[LEN_W-1:0];
      exp_r.dest_h = dh[LEN_W-1:0];
      pending_pixels.push_back(exp_r);
    endfunction

    function void check_pixel_result(rot_result_t got);
      rot_result_t exp_r;
      if (pending_pixels.size() == 0) begin
        flag("result with no read pending", 0, got.pixel);
        return;
      end
      exp_r = pending_pixels.pop_front();
      checked++;
      if (got.pixel !== exp_r.pixel)     flag("pixel_out", exp_r.pixel, got.pixel);
      if (got.last !== exp_r.last)       flag("last_pixel", exp_r.last, got.last);
      if (got.applied !== exp_r.applied) flag("applied", exp_r.applied, got.applied);
      if (got.dest_x !== exp_r.dest_x)   flag("dest_x", exp_r.dest_x, got.dest_x);
      if (got.dest_y !== exp_r.dest_y)   flag("dest_y", exp_r.dest_y, got.dest_y);
      if (got.dest_w !== exp_r.dest_w)   flag("dest_width", exp_r.dest_w, got.dest_w);
      if (got.dest_h !== exp_r.dest_h)   flag("dest_height", exp_r.dest_h, got.dest_h);
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [4:0]                paddr = '0;
  logic [31:0]               pwdata = '0;
  logic [31:0]               prdata;
  logic                      pready;
  logic                      item_valid = 1'b0;
  logic                      item_ready;
  logic                      mode = MODE_LOAD;
  logic [PIX_W-1:0]          pixel_in = '0;
  logic                      result_valid;
  logic                      result_ready = 1'b0;
  logic [PIX_W-1:0]          pixel_out;
  logic                      last_pixel;
  logic                      applied;
  logic signed [COORD_W-1:0] dest_x;
  logic signed [COORD_W-1:0] dest_y;
  logic [LEN_W-1:0]          dest_width;
  logic [LEN_W-1:0]          dest_height;

  rotation_scoreboard sb;
  rot_result_t        seen_result;
  int                 burst_left = 0;
  int                 sink_left = 0;
  int                 sink_style = 0;
  int                 idle_cycles = 0;
  int                 phase_no;
  logic [PIX_W-1:0]   corner_pixels [6] = '{16'hFFFF, 16'h0000, 16'hAAAA,
                                            16'h5555, 16'h8001, 16'h7FFE};

  rect_rotation_engine_unit #(.SCREEN_SIDE(SIDE)) DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .item_valid(item_valid), .item_ready(item_ready),
    .mode(mode), .pixel_in(pixel_in),
    .result_valid(result_valid), .result_ready(result_ready),
    .pixel_out(pixel_out), .last_pixel(last_pixel), .applied(applied),
    .dest_x(dest_x), .dest_y(dest_y),
    .dest_width(dest_width), .dest_height(dest_height)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: always ready, coin toss, or mostly stalled, in stretches
  always @(negedge clk) begin
    if (sink_left == 0) begin
      sink_style = $urandom_range(0, 2);
      sink_left  = $urandom_range(10, 150);
    end
    sink_left--;
    case (sink_style)
      0:       result_ready <= 1'b1;
      1:       result_ready <= 1'($urandom_range(0, 1));
      default: result_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      seen_result.pixel   = pixel_out;
      seen_result.last    = last_pixel;
      seen_result.applied = applied;
      seen_result.dest_x  = dest_x;
      seen_result.dest_y  = dest_y;
      seen_result.dest_w  = dest_width;
      seen_result.dest_h  = dest_height;
      sb.check_pixel_result(seen_result);
    end
  end

  always @(posedge clk) begin
    if ((item_valid && item_ready) || (result_valid && result_ready) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
      $display("rect_rotation_engine_unit test failed");
      $finish;
    end
  end

  task automatic send_request(input logic m, input logic [PIX_W-1:0] pix);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        @(negedge clk);
        item_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    item_valid <= 1'b1;
    mode       <= m;
    pixel_in   <= pix;
    do @(posedge clk); while (!item_ready);
    sb.note_request(m, pix);
  endtask

  task automatic end_requests();
    @(negedge clk);
    item_valid <= 1'b0;
    burst_left = 0;
  endtask

  // loads give no result, so allow the pipe to drain before touching registers
  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, data);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_read(input logic [2:0] idx);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== sb.reg_value(idx))
      sb.flag("register read-back", sb.reg_value(idx), prdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [PIX_W-1:0] random_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  function automatic logic [POS_W-1:0] random_pos();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return POS_W'($urandom);
    endcase
  endfunction

  task automatic run_phase(input int nr);
    logic [LEN_W-1:0] w, h;
    logic [31:0]      junk;
    rot_t             r;
    int               frame, n, loaded;
    bit               orderly;
    logic             m;
    if (nr == 0) begin
      w = LEN_W'(SIDE);
      h = LEN_W'($urandom_range(1, 2));
    end else if (nr == 1) begin
      w = LEN_W'($urandom_range(1, 2));
      h = LEN_W'(SIDE);
    end else begin
      w = LEN_W'($urandom_range(1, 12));
      h = LEN_W'($urandom_range(1, 12));
    end
    r = rot_t'($urandom_range(0, 3));
    if (nr < 2 && r == ROT_NONE)
      r = ROT_90;
    wait_idle();
    junk = $urandom;
    if ($urandom_range(0, 3) != 0) apb_write(REG_SRC_X, {junk[31:POS_W], random_pos()});
    junk = $urandom;
    if ($urandom_range(0, 3) != 0) apb_write(REG_SRC_Y, {junk[31:POS_W], random_pos()});
    junk = $urandom;
    apb_write(REG_RECT_WIDTH, {junk[31:LEN_W], w});
    junk = $urandom;
    apb_write(REG_RECT_HEIGHT, {junk[31:LEN_W], h});
    junk = $urandom;
    if (nr < 2 || $urandom_range(0, 3) != 0) apb_write(REG_ROTATION, {junk[31:ROT_W], r});
    if ($urandom_range(0, 5) == 0)
      apb_write(3'(NUM_REGS + $urandom_range(0, 2)), $urandom);
    for (int i = 0; i < NUM_REGS; i++)
      apb_read(3'(i));

    frame   = int'(w) * int'(h);
    orderly = ($urandom_range(0, 9) < 7);
    n       = (frame > 100) ? frame + $urandom_range(10, 40) : $urandom_range(30, 110);
    loaded  = 0;
    for (int i = 0; i < n; i++) begin
      if (orderly)
        m = (loaded < frame) ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 6) != 0);
      else
        m = 1'($urandom_range(0, 1));
      if (m == MODE_READ && !sb.read_allowed())
        m = MODE_LOAD;
      if (m == MODE_LOAD)
        loaded++;
      send_request(m, random_pixel());
    end
    end_requests();
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset values, then pass-through on the full screen
    for (int i = 0; i < NUM_REGS; i++)
      apb_read(3'(i));
    send_request(MODE_READ, 16'h0000);
    send_request(MODE_LOAD, 16'hFFFF);
    send_request(MODE_READ, 16'hFFFF);
    end_requests();

    // quarter turn at the far corner, destination wraps negative
    wait_idle();
    apb_write(REG_SRC_X, 32'hFFFF_FFFF);
    apb_write(REG_SRC_Y, 32'h0000_00FF);
    apb_write(REG_RECT_WIDTH, 32'd2);
    apb_write(REG_RECT_HEIGHT, 32'd3);
    apb_write(REG_ROTATION, {30'h3FFF_FFFF, ROT_90});
    foreach (corner_pixels[i])
      send_request(MODE_LOAD, corner_pixels[i]);
    repeat (7) send_request(MODE_READ, 16'h0000);
    end_requests();

    // unmapped register must leave the counters alone
    wait_idle();
    apb_write(3'(NUM_REGS), 32'hFFFF_FFFF);
    repeat (2) send_request(MODE_READ, 16'h0000);
    end_requests();

    wait_idle();
    apb_write(REG_SRC_X, 32'd0);
    apb_write(REG_SRC_Y, 32'd0);
    apb_write(REG_RECT_WIDTH, 32'd1);
    apb_write(REG_RECT_HEIGHT, 32'd1);
    apb_write(REG_ROTATION, 32'(ROT_180));
    send_request(MODE_LOAD, 16'h1234);
    repeat (2) send_request(MODE_READ, 16'h0000);
    end_requests();

    wait_idle();
    apb_write(REG_RECT_HEIGHT, 32'd2);
    apb_write(REG_ROTATION, 32'(ROT_270));
    send_request(MODE_LOAD, 16'h8000);
    send_request(MODE_LOAD, 16'h0001);
    repeat (2) send_request(MODE_READ, 16'h0000);
    end_requests();

    phase_no = 0;
    while (sb.loads + sb.reads < WANT_REQS) begin
      run_phase(phase_no);
      phase_no++;
    end

    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d loads, %0d ignored loads and %0d reads over %0d register settings",
             sb.loads, sb.ignored, sb.reads, sb.settings);
    $display("%0d results compared across %0d random phases, %0d mismatches",
             sb.checked, phase_no, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("rect_rotation_engine_unit test passed");
    end else begin
      $display("rect_rotation_engine_unit test failed");
    end
    $finish;
  end

endmodule
